### src/aes_block_cipher_cbc_assert.svh
// ----------------------------------------------------------------------------
// aes assertion macros
// shared concurrent assertion helpers for the aes block
// ----------------------------------------------------------------------------
`ifndef AES_BLOCK_CIPHER_CBC_ASSERT_SVH
`define AES_BLOCK_CIPHER_CBC_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define AES_ASSERT_IMP(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define AES_ASSERT_NXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define AES_ASSERT_IMP(lbl, clk, rst, a, c)
`define AES_ASSERT_NXT(lbl, clk, rst, a, c)
`endif
`endif

### src/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes package
// shared types, codes and round functions
// ----------------------------------------------------------------------------
package aes_pkg;
   localparam logic [2:0] CSR_KEY0 = 3'd0;
   localparam logic [2:0] CSR_KEY1 = 3'd1;
   localparam logic [2:0] CSR_KEY2 = 3'd2;
   localparam logic [2:0] CSR_KEY3 = 3'd3;
   localparam logic [2:0] CSR_KLEN = 3'd4;
   localparam logic [2:0] CSR_MODE = 3'd5;
   localparam logic [2:0] CSR_IVH  = 3'd6;
   localparam logic [2:0] CSR_IVL  = 3'd7;

   typedef struct packed {
      logic load;      // capture item, start schedule
      logic key_step;  // compute next schedule word
      logic round;     // one cipher round
      logic finish;    // final round and chaining
   } aes_cmd_type;

   typedef struct packed {
      logic       key_done;
      logic       last_round;
   } aes_status_type;

   function automatic logic [7:0] xt(input logic [7:0] x);
      xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      logic [7:0] t;
      r = 8'h00;
      t = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r = r ^ t;
         t = xt(t);
      end
      gmul = r;
   endfunction

   function automatic logic [7:0] inv8(input logic [7:0] a);
      logic [7:0] r;
      logic [7:0] p;
      r = 8'h01;
      p = a;
      // a^254 by square and multiply
      for (int i = 1; i < 8; i++) begin
         p = gmul(p, p);
         r = gmul(r, p);
      end
      inv8 = r;
   endfunction

   function automatic logic [7:0] sbox_calc(input logic [7:0] a);
      logic [7:0] v;
      v = inv8(a);
      sbox_calc = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                  ^ {v[3:0], v[7:4]} ^ 8'h63;
   endfunction

   typedef logic [7:0] byte_tab_type [256];

   function automatic byte_tab_type make_sbox();
      byte_tab_type t;
      for (int i = 0; i < 256; i++) t[i] = sbox_calc(8'(i));
      return t;
   endfunction

   function automatic byte_tab_type make_inv();
      byte_tab_type t;
      for (int i = 0; i < 256; i++) t[sbox_calc(8'(i))] = 8'(i);
      return t;
   endfunction

   localparam byte_tab_type SBOX = make_sbox();
   localparam byte_tab_type INV_SBOX = make_inv();
endpackage

### src/aes_block_cipher_cbc.sv
// ----------------------------------------------------------------------------
// aes block cipher, ecb and cbc
// one 128-bit block per item with 128/192/256-bit keys
// ----------------------------------------------------------------------------
// each item: key schedule words, then the cipher rounds and a final round, then the
// result is held until taken; the schedule is rebuilt per item
// a new item is accepted only in idle, after the previous result has been taken
// reset: synchronous, active high; clears keys, klen, mode, iv and chaining value
module aes_block_cipher_cbc (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic        req_first_block,
   input  logic [63:0] req_block_high,
   input  logic [63:0] req_block_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result_high,
   output logic [63:0] rsp_result_low,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   import aes_pkg::*;

   aes_cmd_type    cmd;     // controller to datapath
   aes_status_type status;  // datapath to controller

   // controller: handshake and sequencing
   aes_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
      .status, .cmd
   );

   // datapath: schedule, rounds, chaining
   aes_dp u_dp (
      .clock, .reset, .cmd, .status, .csr_write, .csr_index, .csr_data,
      .req_opcode, .req_first_block, .req_block_high, .req_block_low,
      .rsp_result_high, .rsp_result_low
   );
endmodule

### src/aes_ctrl.sv
// ----------------------------------------------------------------------------
// aes controller
// sequences load, key expansion and cipher rounds
// ----------------------------------------------------------------------------
`include "aes_block_cipher_cbc_assert.svh"
module aes_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  aes_pkg::aes_status_type status,
   output aes_pkg::aes_cmd_type    cmd
);
   import aes_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_KEY   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_LAST  = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.load     = accept;
      cmd.key_step = (state_ff == ST_KEY);
      cmd.round    = (state_ff == ST_ROUND);
      cmd.finish   = (state_ff == ST_LAST);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_KEY;
         ST_KEY:   if (status.key_done) state_in = ST_ROUND;
         ST_ROUND: if (status.last_round) state_in = ST_LAST;
         ST_LAST:  state_in = ST_OUT;
         ST_OUT:   if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   `AES_ASSERT_NXT(a_accept_key, clock, reset, accept, state_ff == ST_KEY)
   `AES_ASSERT_NXT(a_last_out, clock, reset, state_ff == ST_LAST, rsp_valid)
   `AES_ASSERT_IMP(a_excl, clock, reset, rsp_valid, req_stall)
endmodule

### src/aes_dp.sv
// ----------------------------------------------------------------------------
// aes datapath
// key schedule memory, round unit, chaining registers
// ----------------------------------------------------------------------------
`include "aes_block_cipher_cbc_assert.svh"
module aes_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  aes_pkg::aes_cmd_type    cmd,
   output aes_pkg::aes_status_type status,
   input  logic                    csr_write,
   input  logic [2:0]              csr_index,
   input  logic [63:0]             csr_data,
   input  logic                    req_opcode,
   input  logic                    req_first_block,
   input  logic [63:0]             req_block_high,
   input  logic [63:0]             req_block_low,
   output logic [63:0]             rsp_result_high,
   output logic [63:0]             rsp_result_low
);
   import aes_pkg::*;

   logic [63:0]  key_ff [4];
   logic [1:0]   klen_ff;
   logic         mode_ff;
   logic [63:0]  ivh_ff, ivl_ff;
   logic [127:0] chain_ff;

   logic [127:0] rk_ff [15];     // schedule, one round key per entry, filled a word a cycle
   logic [5:0]   widx_ff;        // next word to compute
   logic [255:0] win_ff;         // last nk words, newest in low bits
   logic [7:0]   rcon_ff;
   logic [2:0]   kmod_ff;        // word index mod nk
   logic [3:0]   rnd_ff;
   logic [127:0] st_ff, res_ff;
   logic         dec_ff, first_ff;
   logic [127:0] blk_ff;

   logic [3:0] nk;
   logic [3:0] nr;
   logic [5:0] total;
   assign nk    = klen_ff[1] ? 4'd8 : (klen_ff[0] ? 4'd6 : 4'd4);
   assign nr    = nk + 4'd6;
   assign total = {nr, 2'b00} + 6'd4;

   // next schedule word
   logic [31:0] prev, far, t, sw, nextw;
   always_comb begin
      prev = win_ff[31:0];
      priority case (nk)
         4'd4:    far = win_ff[127:96];
         4'd6:    far = win_ff[191:160];
         default: far = win_ff[255:224];
      endcase
      sw = {SBOX[prev[23:16]], SBOX[prev[15:8]], SBOX[prev[7:0]], SBOX[prev[31:24]]};
      t = prev;
      if (kmod_ff == 3'd0)
         t = sw ^ {rcon_ff, 24'h0};
      else if (nk == 4'd8 && kmod_ff == 3'd4)
         t = {SBOX[prev[31:24]], SBOX[prev[23:16]], SBOX[prev[15:8]], SBOX[prev[7:0]]};
      nextw = far ^ t;
   end

   assign status.key_done   = cmd.key_step && (widx_ff == total - 6'd1);
   assign status.last_round = cmd.round && (rnd_ff == nr - 4'd1);

   // round key read: encrypt uses round rnd, decrypt uses nr - rnd
   logic [3:0]   kr;
   logic [127:0] rkey;
   assign kr    = dec_ff ? (nr - rnd_ff) : rnd_ff;
   assign rkey  = rk_ff[kr];

   // one round of the cipher on st_ff; byte i at bits 127-8i
   function automatic logic [7:0] gb(input logic [127:0] s, input int i);
      return s[127 - 8*i -: 8];
   endfunction

   logic [127:0] fwd_sr, inv_sr, fwd_mc, inv_mc, mc_in;
   always_comb begin
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            fwd_sr[127 - 8*(r+4*c) -: 8] = SBOX[gb(st_ff, r + 4*((c+r)&3))];
            inv_sr[127 - 8*(r+4*((c+r)&3)) -: 8] = INV_SBOX[gb(st_ff, r + 4*c)];
         end
      mc_in = inv_sr ^ rkey;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            fwd_mc[127 - 8*(4*c+r) -: 8] =
               gmul(gb(fwd_sr, 4*c + r), 8'h02) ^ gmul(gb(fwd_sr, 4*c + ((r+1)&3)), 8'h03)
               ^ gb(fwd_sr, 4*c + ((r+2)&3)) ^ gb(fwd_sr, 4*c + ((r+3)&3));
            inv_mc[127 - 8*(4*c+r) -: 8] =
               gmul(gb(mc_in, 4*c + r), 8'h0e) ^ gmul(gb(mc_in, 4*c + ((r+1)&3)), 8'h0b)
               ^ gmul(gb(mc_in, 4*c + ((r+2)&3)), 8'h0d)
               ^ gmul(gb(mc_in, 4*c + ((r+3)&3)), 8'h09);
         end
   end

   logic [127:0] chain_sel, pre, last_out;
   assign chain_sel = first_ff ? {ivh_ff, ivl_ff} : chain_ff;
   assign pre = (!dec_ff && mode_ff) ? (blk_ff ^ chain_sel) : blk_ff;
   assign last_out = dec_ff ? ((inv_sr ^ rkey) ^ (mode_ff ? chain_sel : 128'h0))
                            : (fwd_sr ^ rkey);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) key_ff[i] <= '0;
         klen_ff  <= '0;
         mode_ff  <= 1'b0;
         ivh_ff   <= '0;
         ivl_ff   <= '0;
         chain_ff <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_KEY0: key_ff[0] <= csr_data;
               CSR_KEY1: key_ff[1] <= csr_data;
               CSR_KEY2: key_ff[2] <= csr_data;
               CSR_KEY3: key_ff[3] <= csr_data;
               CSR_KLEN: klen_ff   <= csr_data[1:0];
               CSR_MODE: mode_ff   <= csr_data[0];
               CSR_IVH:  ivh_ff    <= csr_data;
               CSR_IVL:  ivl_ff    <= csr_data;
               default:  ;
            endcase
         end
         if (cmd.finish && mode_ff)
            chain_ff <= dec_ff ? blk_ff : last_out;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dec_ff   <= req_opcode;
         first_ff <= req_first_block;
         blk_ff   <= {req_block_high, req_block_low};
         // key words 0..7 copied straight in, newest word in low bits
         rk_ff[0] <= {key_ff[0], key_ff[1]};
         rk_ff[1] <= {key_ff[2], key_ff[3]};
         priority case (nk)
            4'd4:    win_ff <= {128'h0, key_ff[0], key_ff[1]};
            4'd6:    win_ff <= {64'h0, key_ff[0], key_ff[1], key_ff[2]};
            default: win_ff <= {key_ff[0], key_ff[1], key_ff[2], key_ff[3]};
         endcase
         widx_ff <= {2'b00, nk};
         kmod_ff <= 3'd0;
         rcon_ff <= 8'h01;
         rnd_ff  <= 4'd0;
      end else if (cmd.key_step) begin
         rk_ff[widx_ff[5:2]][{~widx_ff[1:0], 5'b00000} +: 32] <= nextw;
         win_ff  <= {win_ff[223:0], nextw};
         widx_ff <= widx_ff + 6'd1;
         kmod_ff <= (kmod_ff == 3'(nk - 4'd1)) ? 3'd0 : kmod_ff + 3'd1;
         if (kmod_ff == 3'd0) rcon_ff <= xt(rcon_ff);
         if (status.key_done) begin
            st_ff  <= pre ^ (dec_ff ? {rk_ff[nr][127:32], nextw} : rk_ff[0]);
            rnd_ff <= 4'd1;
         end
      end else if (cmd.round) begin
         st_ff  <= dec_ff ? inv_mc : (fwd_mc ^ rkey);
         rnd_ff <= rnd_ff + 4'd1;
      end else if (cmd.finish) begin
         res_ff <= last_out;
      end
   end

   assign rsp_result_high = res_ff[127:64];
   assign rsp_result_low  = res_ff[63:0];

   `AES_ASSERT_IMP(a_widx, clock, reset, cmd.key_step, widx_ff < 6'd60)
   `AES_ASSERT_IMP(a_rnd, clock, reset, cmd.round, rnd_ff < nr)
   `AES_ASSERT_NXT(a_key_rnd, clock, reset, status.key_done, rnd_ff == 4'd1)
endmodule
